### rtl/core/ebd_pkg.sv
// Package: shared types and constants for the edge event button debouncer.
`timescale 1ns / 1ps
package ebd_pkg;

    localparam int NUM_BUTTONS = 2;
    localparam int TIME_W      = 32;
    localparam int TICK_W      = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_QUIET_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_DURATION = 1'b1;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_EDGE = 1'b1;

    localparam logic [TICK_W-1:0] QUIET_TIMEOUT_RST = 16'd10;
    localparam logic [TICK_W-1:0] FLASH_DURATION_RST = 16'd200;

    typedef enum logic [3:0] {
        PH_UP      = 4'b0001,
        PH_FALLING = 4'b0010,
        PH_DOWN    = 4'b0100,
        PH_RISING  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic              cmd;
        logic              button_index;
        logic              is_rising;
        logic [TIME_W-1:0] event_time;
    } in_item_t;

    typedef struct packed {
        logic              which_button;
        logic              is_release;
        logic [TIME_W-1:0] edge_time;
        logic [TICK_W-1:0] flash_ticks;
        logic              last;
    } out_item_t;

    // One quiet-timer firing: which buttons confirmed, their kind and time.
    typedef struct packed {
        logic [NUM_BUTTONS-1:0]             mask;
        logic [NUM_BUTTONS-1:0]             rel;
        logic [NUM_BUTTONS-1:0][TIME_W-1:0] times;
        logic [TICK_W-1:0]                  flash;
    } fire_rec_t;

endpackage

### rtl/core/ebd_front.sv
// Front end: accepts transactions, tracks button phases and the quiet timer.
`timescale 1ns / 1ps
module ebd_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ebd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ebd_pkg::TICK_W-1:0]      cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ebd_pkg::in_item_t               s_data,
    input  logic                            q_full,
    output logic                            push,
    output ebd_pkg::fire_rec_t              push_rec
);
    import ebd_pkg::*;

    logic [TICK_W-1:0] timeout_reg, timeout_next;
    logic [TICK_W-1:0] flash_reg, flash_next;
    logic [TICK_W-1:0] qc_reg, qc_next;
    phase_t            phase_reg [NUM_BUTTONS];
    phase_t            phase_next [NUM_BUTTONS];
    logic [TIME_W-1:0] time_reg [NUM_BUTTONS];
    logic [TIME_W-1:0] time_next [NUM_BUTTONS];

    logic              accept;
    logic [TICK_W-1:0] limit;
    logic [TICK_W-1:0] qc_inc;
    logic              fire;
    logic              hit;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign limit   = (timeout_reg == '0) ? TICK_W'(1) : timeout_reg;
    assign qc_inc  = (qc_reg == '1) ? qc_reg : qc_reg + 1'b1;
    assign fire    = qc_inc >= limit;

    always_comb begin
        timeout_next = timeout_reg;
        flash_next   = flash_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_QUIET_TIMEOUT:  timeout_next = cfg_wdata;
                REG_FLASH_DURATION: flash_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        qc_next = qc_reg;
        push_rec.mask  = '0;
        push_rec.rel   = '0;
        push_rec.flash = flash_reg;
        hit = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            phase_next[i] = phase_reg[i];
            time_next[i]  = time_reg[i];
            push_rec.times[i] = time_reg[i];
        end
        if (accept && s_data.cmd == CMD_EDGE) begin
            qc_next = '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                hit = (32'(s_data.button_index) == i);
                if (hit) begin
                    case (phase_reg[i])
                        PH_UP: begin
                            if (!s_data.is_rising) begin
                                phase_next[i] = PH_FALLING;
                                time_next[i]  = s_data.event_time;
                            end
                        end
                        PH_FALLING: begin
                            phase_next[i] = PH_UP;
                            time_next[i]  = s_data.event_time;
                        end
                        PH_DOWN: begin
                            if (s_data.is_rising) begin
                                phase_next[i] = PH_RISING;
                                time_next[i]  = s_data.event_time;
                            end
                        end
                        PH_RISING: begin
                            phase_next[i] = PH_DOWN;
                            time_next[i]  = s_data.event_time;
                        end
                        default: ;
                    endcase
                end
            end
        end else if (accept) begin
            qc_next = fire ? '0 : qc_inc;
            if (fire) begin
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    case (phase_reg[i])
                        PH_FALLING: begin
                            push_rec.mask[i] = 1'b1;
                            phase_next[i]    = PH_DOWN;
                        end
                        PH_RISING: begin
                            push_rec.mask[i] = 1'b1;
                            push_rec.rel[i]  = 1'b1;
                            phase_next[i]    = PH_UP;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    assign push = accept && s_data.cmd == CMD_TICK && fire && (|push_rec.mask);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= QUIET_TIMEOUT_RST;
            flash_reg   <= FLASH_DURATION_RST;
            qc_reg      <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                phase_reg[i] <= PH_UP;
                time_reg[i]  <= '0;
            end
        end else begin
            timeout_reg <= timeout_next;
            flash_reg   <= flash_next;
            qc_reg      <= qc_next;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                phase_reg[i] <= phase_next[i];
                time_reg[i]  <= time_next[i];
            end
        end
    end

endmodule

### rtl/core/ebd_queue.sv
// Short FIFO of firing records between the front and back ends.
`timescale 1ns / 1ps
module ebd_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ebd_pkg::fire_rec_t push_rec,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output ebd_pkg::fire_rec_t head
);
    import ebd_pkg::*;

    fire_rec_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

### rtl/core/ebd_back.sv
// Back end: expands firing records into one result transaction per confirmed button.
`timescale 1ns / 1ps
module ebd_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_not_empty,
    input  ebd_pkg::fire_rec_t          q_head,
    output logic                        q_pop,
    output logic                        work_pending,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ebd_pkg::out_item_t          m_data
);
    import ebd_pkg::*;

    fire_rec_t              work_reg, work_next;
    logic [NUM_BUTTONS-1:0] mask_reg, mask_next;
    out_item_t              out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic [NUM_BUTTONS-1:0] sel;
    logic [NUM_BUTTONS-1:0] mask_rest;
    logic                   out_free;
    logic                   emit;
    logic                   sel_btn;
    logic                   sel_rel;
    logic [TIME_W-1:0]      sel_time;

    // lowest pending button first
    always_comb begin
        sel      = '0;
        sel_btn  = 1'b0;
        sel_rel  = 1'b0;
        sel_time = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel      = '0;
                sel[i]   = 1'b1;
                sel_btn  = 1'(i);
                sel_rel  = work_reg.rel[i];
                sel_time = work_reg.times[i];
            end
        end
    end

    assign out_free  = !out_valid_reg || m_ready;
    assign emit      = out_free && (|mask_reg);
    assign mask_rest = mask_reg & ~sel;
    assign q_pop     = q_not_empty && ((emit ? mask_rest : mask_reg) == '0);

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        mask_next      = emit ? mask_rest : mask_reg;
        work_next      = work_reg;
        if (emit) begin
            out_next.which_button = sel_btn;
            out_next.is_release   = sel_rel;
            out_next.edge_time    = sel_time;
            out_next.flash_ticks  = work_reg.flash;
            out_next.last         = (mask_rest == '0);
            out_valid_next        = 1'b1;
        end
        if (q_pop) begin
            work_next = q_head;
            mask_next = q_head.mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
        work_reg <= work_next;
        out_reg  <= out_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_data       = out_reg;
    assign work_pending = |mask_reg;

endmodule

### rtl/core/edge_event_button_debouncer_top.sv
// Top level: edge event button debouncer, front end, record queue, back end.
// A confirming tick's record passes the queue slot, the work register and then the result register.
// Throughput: one transaction per cycle in; a firing with k confirmations
// gives k results in turn through the single result register, buffered by a 2-entry queue.
// Input ready drops only while that queue is full.
// Reset (aresetn, synchronous, active low): all buttons up, times and quiet count zero,
// timeout 10 and flash duration 200; the queue and result register are emptied.
`timescale 1ns / 1ps
module edge_event_button_debouncer_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ebd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ebd_pkg::TICK_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ebd_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ebd_pkg::out_item_t            m_data
);
    import ebd_pkg::*;

    logic      push;
    fire_rec_t push_rec;
    logic      q_full;
    logic      q_pop;
    logic      q_not_empty;
    fire_rec_t q_head;
    logic      work_pending;

    ebd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .push      (push),
        .push_rec  (push_rec)
    );

    ebd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_rec  (push_rec),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    ebd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .work_pending (work_pending),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("record pushed into full queue");

    a_push_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (s_valid && s_ready && s_data.cmd == CMD_TICK))
        else $error("record pushed without an accepted tick");

    a_more_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> work_pending)
        else $error("non-final result with no further confirmation pending");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty)
        else $error("pop from empty queue");

endmodule

### tb/sv/testbench.sv
// Testbench for the edge event button debouncer: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps
module testbench;
    import ebd_pkg::*;

    typedef struct packed {
        logic                 cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [TICK_W-1:0]    reg_val;
        in_item_t             item;
        logic                 typed;
        logic [1:0]           n_typed;
        out_item_t            typ0;
        out_item_t            typ1;
    } stim_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TICK_W-1:0]    cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;

    edge_event_button_debouncer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [TICK_W-1:0] quiet_limit;
    logic [TICK_W-1:0] flash_len;
    logic [TICK_W-1:0] quiet_cnt;
    phase_t            btn_phase [NUM_BUTTONS];
    logic [TIME_W-1:0] btn_time  [NUM_BUTTONS];

    out_item_t pending_results [$];
    stim_row_t dir_tbl [$];
    int        errors             = 0;
    int        items_sent         = 0;
    int        sender_idle_pct    = 0;
    int        receiver_stall_pct = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic debounce_step(input in_item_t it, output int n,
                                 output out_item_t r0, output out_item_t r1);
        logic [TICK_W-1:0] lim;
        phase_t            ph;
        out_item_t         r;
        n  = 0;
        r0 = '0;
        r1 = '0;
        if (it.cmd == CMD_EDGE) begin
            quiet_cnt = '0;
            ph = btn_phase[it.button_index];
            case (ph)
                PH_UP: begin
                    if (!it.is_rising) begin
                        btn_phase[it.button_index] = PH_FALLING;
                        btn_time[it.button_index]  = it.event_time;
                    end
                end
                PH_FALLING: begin
                    btn_phase[it.button_index] = PH_UP;
                    btn_time[it.button_index]  = it.event_time;
                end
                PH_DOWN: begin
                    if (it.is_rising) begin
                        btn_phase[it.button_index] = PH_RISING;
                        btn_time[it.button_index]  = it.event_time;
                    end
                end
                default: begin
                    btn_phase[it.button_index] = PH_DOWN;
                    btn_time[it.button_index]  = it.event_time;
                end
            endcase
        end else begin
            lim = (quiet_limit == '0) ? TICK_W'(1) : quiet_limit;
            if (quiet_cnt != '1)
                quiet_cnt = quiet_cnt + 1'b1;
            if (quiet_cnt >= lim) begin
                quiet_cnt = '0;
                for (int b = 0; b < NUM_BUTTONS; b++) begin
                    ph = btn_phase[b];
                    if (ph == PH_FALLING || ph == PH_RISING) begin
                        r.which_button = 1'(b);
                        r.is_release   = (ph == PH_RISING);
                        r.edge_time    = btn_time[b];
                        r.flash_ticks  = flash_len;
                        r.last         = 1'b0;
                        btn_phase[b]   = (ph == PH_FALLING) ? PH_DOWN : PH_UP;
                        if (n == 0)
                            r0 = r;
                        else
                            r1 = r;
                        n++;
                    end
                end
                if (n == 1)
                    r0.last = 1'b1;
                if (n == 2)
                    r1.last = 1'b1;
            end
        end
    endtask

    task automatic send_item(input in_item_t it, input logic typed, input int n_typed,
                             input out_item_t t0, input out_item_t t1);
        int        n;
        out_item_t p0;
        out_item_t p1;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (s_ready !== 1'b1)
            @(posedge aclk);
        debounce_step(it, n, p0, p1);
        if (typed) begin
            n  = n_typed;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0)
            pending_results.push_back(p0);
        if (n > 1)
            pending_results.push_back(p1);
        items_sent++;
        @(negedge aclk);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        if (idx == REG_QUIET_TIMEOUT)
            quiet_limit = val;
        else
            flash_len = val;
    endtask

    function automatic out_item_t conf(logic btn, logic rel, logic [TIME_W-1:0] t,
                                       logic [TICK_W-1:0] fl, logic lst);
        out_item_t r;
        r.which_button = btn;
        r.is_release   = rel;
        r.edge_time    = t;
        r.flash_ticks  = fl;
        r.last         = lst;
        return r;
    endfunction

    function automatic stim_row_t edge_row(logic btn, logic rising, logic [TIME_W-1:0] t);
        stim_row_t r;
        r = '0;
        r.item.cmd          = CMD_EDGE;
        r.item.button_index = btn;
        r.item.is_rising    = rising;
        r.item.event_time   = t;
        return r;
    endfunction

    function automatic stim_row_t tick_row();
        stim_row_t r;
        r = '0;
        r.item.cmd        = CMD_TICK;
        r.item.event_time = $urandom;
        return r;
    endfunction

    function automatic stim_row_t typed_tick(int n, out_item_t a, out_item_t b);
        stim_row_t r;
        r = tick_row();
        r.typed   = 1'b1;
        r.n_typed = 2'(n);
        r.typ0    = a;
        r.typ1    = b;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
        stim_row_t r;
        r = '0;
        r.cfg     = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it.cmd          = ($urandom_range(99) < 55) ? CMD_TICK : CMD_EDGE;
        it.button_index = 1'($urandom_range(1));
        it.is_rising    = 1'($urandom_range(1));
        it.event_time   = rand_time();
        return it;
    endfunction

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", 64'(m_data), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_data.which_button !== want.which_button)
                    report_mismatch("which_button", 64'(m_data.which_button),
                                    64'(want.which_button));
                if (m_data.is_release !== want.is_release)
                    report_mismatch("is_release", 64'(m_data.is_release),
                                    64'(want.is_release));
                if (m_data.edge_time !== want.edge_time)
                    report_mismatch("edge_time", 64'(m_data.edge_time),
                                    64'(want.edge_time));
                if (m_data.flash_ticks !== want.flash_ticks)
                    report_mismatch("flash_ticks", 64'(m_data.flash_ticks),
                                    64'(want.flash_ticks));
                if (m_data.last !== want.last)
                    report_mismatch("last", 64'(m_data.last), 64'(want.last));
            end
        end
    end

    initial begin : stimulus
        stim_row_t         row;
        in_item_t          it;
        logic [TICK_W-1:0] lim;
        int                phase_start;
        int                waited;
        logic              paused;
        quiet_limit = QUIET_TIMEOUT_RST;
        flash_len   = FLASH_DURATION_RST;
        quiet_cnt   = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            btn_phase[b] = PH_UP;
            btn_time[b]  = '0;
        end
        paused = 1'b0;

        // press confirmed with reset settings
        dir_tbl.push_back(edge_row(1'b0, 1'b0, 32'hFFFF_FFFF));
        repeat (9) dir_tbl.push_back(tick_row());
        dir_tbl.push_back(typed_tick(1, conf(1'b0, 1'b0, 32'hFFFF_FFFF, 16'd200, 1'b1), '0));
        // zero timeout, max flash; two confirmations on one tick
        dir_tbl.push_back(cfg_row(REG_QUIET_TIMEOUT, 16'd0));
        dir_tbl.push_back(cfg_row(REG_FLASH_DURATION, 16'hFFFF));
        dir_tbl.push_back(edge_row(1'b1, 1'b0, 32'h0000_0000));
        dir_tbl.push_back(edge_row(1'b0, 1'b1, 32'h1234_5678));
        dir_tbl.push_back(typed_tick(2, conf(1'b0, 1'b1, 32'h1234_5678, 16'hFFFF, 1'b0),
                                        conf(1'b1, 1'b0, 32'h0000_0000, 16'hFFFF, 1'b1)));
        // ignored edges, then an idle firing
        dir_tbl.push_back(edge_row(1'b0, 1'b1, 32'd5));
        dir_tbl.push_back(edge_row(1'b1, 1'b0, 32'd6));
        dir_tbl.push_back(typed_tick(0, '0, '0));
        // bounce back to up
        dir_tbl.push_back(edge_row(1'b0, 1'b0, 32'hAAAA_AAAA));
        dir_tbl.push_back(edge_row(1'b0, 1'b1, 32'h5555_5555));
        dir_tbl.push_back(tick_row());
        // max timeout, zero flash; bounce while rising
        dir_tbl.push_back(cfg_row(REG_QUIET_TIMEOUT, 16'hFFFF));
        dir_tbl.push_back(cfg_row(REG_FLASH_DURATION, 16'd0));
        dir_tbl.push_back(edge_row(1'b1, 1'b1, 32'd1));
        dir_tbl.push_back(edge_row(1'b1, 1'b0, 32'd2));
        dir_tbl.push_back(edge_row(1'b1, 1'b1, 32'd3));
        dir_tbl.push_back(tick_row());
        dir_tbl.push_back(tick_row());
        // timeout lowered below the running count
        dir_tbl.push_back(cfg_row(REG_QUIET_TIMEOUT, 16'd1));
        dir_tbl.push_back(typed_tick(1, conf(1'b1, 1'b1, 32'd3, 16'd0, 1'b1), '0));

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_tbl[i]) begin
            row = dir_tbl[i];
            if (row.cfg) begin
                drain_results();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_item(row.item, row.typed, int'(row.n_typed), row.typ0, row.typ1);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            case (ph)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                    write_reg(REG_QUIET_TIMEOUT, 16'd1);
                    write_reg(REG_FLASH_DURATION, 16'hFFFF);
                end
                1: begin
                    sender_idle_pct    = 50;
                    receiver_stall_pct = 0;
                    write_reg(REG_QUIET_TIMEOUT, 16'd0);
                    write_reg(REG_FLASH_DURATION, TICK_W'($urandom_range(65535)));
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 50;
                    write_reg(REG_QUIET_TIMEOUT, TICK_W'($urandom_range(4, 2)));
                    write_reg(REG_FLASH_DURATION, 16'd0);
                end
                default: begin
                    sender_idle_pct    = 10;
                    receiver_stall_pct = 10;
                    write_reg(REG_QUIET_TIMEOUT, 16'd3);
                    write_reg(REG_FLASH_DURATION, TICK_W'($urandom_range(65535)));
                end
            endcase
            phase_start = items_sent;
            while (items_sent < phase_start + 200) begin
                if (ph == 1 && !paused && items_sent >= phase_start + 100) begin
                    drain_results();
                    paused = 1'b1;
                end
                if ($urandom_range(9) < 7) begin
                    // press or release with bounces, then enough quiet ticks to confirm
                    for (int b = 0; b < NUM_BUTTONS; b++) begin
                        if ($urandom_range(9) < 6) begin
                            repeat ($urandom_range(3, 1)) begin
                                it.cmd          = CMD_EDGE;
                                it.button_index = 1'(b);
                                if (btn_phase[b] == PH_UP)
                                    it.is_rising = 1'b0;
                                else if (btn_phase[b] == PH_DOWN)
                                    it.is_rising = 1'b1;
                                else
                                    it.is_rising = 1'($urandom_range(1));
                                it.event_time = rand_time();
                                send_item(it, 1'b0, 0, '0, '0);
                            end
                        end
                    end
                    lim = (quiet_limit == '0) ? TICK_W'(1) : quiet_limit;
                    repeat (int'(lim) + $urandom_range(1)) begin
                        it            = rand_item();
                        it.cmd        = CMD_TICK;
                        send_item(it, 1'b0, 0, '0, '0);
                    end
                end else begin
                    send_item(rand_item(), 1'b0, 0, '0, '0);
                end
            end
        end

        s_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000) begin
            @(negedge aclk);
            waited++;
        end
        if (pending_results.size() != 0)
            report_mismatch("transactions never delivered", 64'(pending_results.size()),
                            64'd0);
        repeat (10) @(negedge aclk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
